// ===== rtl/rmsw_pkg.sv =====
// Shared types and constants for the RMS-over-window block.
// Used by rmsw_front, rmsw_fifo, rmsw_back and the top level; no dependencies.
`timescale 1ns / 1ps

package rmsw_pkg;

   // Window queue between the accumulator and the divide/root unit
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PTR_BITS     = $clog2(QUEUE_DEPTH);

   // Window length after reset
   localparam int unsigned WINDOW_RESET = 30;

   typedef struct packed {
      logic                   empty;
      logic [QCOUNT_BITS-1:0] count;
   } queue_status_type;

endpackage

// ===== rtl/rmsw_front.sv =====
// Front end: takes samples, squares them, accumulates and closes windows.
// Depends on rmsw_pkg; pushes closed windows into rmsw_fifo.
`timescale 1ns / 1ps

module rmsw_front #(
   parameter int unsigned SAMPLE_BITS = 10,
   parameter int unsigned LENGTH_BITS = 8,
   parameter int unsigned SUM_BITS    = 28
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic                             csr_write,
   input  logic [LENGTH_BITS-1:0]           csr_window_length,
   input  rmsw_pkg::queue_status_type       queue_status,
   output logic                             queue_push,
   output logic [SUM_BITS+LENGTH_BITS-1:0]  queue_data
);

   logic [LENGTH_BITS-1:0]                window_ff, window_in;
   logic [LENGTH_BITS-1:0]                count_ff, count_in;
   logic [LENGTH_BITS-1:0]                count_next;
   logic [LENGTH_BITS-1:0]                len_eff;
   logic                                  close_now;
   logic                                  accept;
   logic [rmsw_pkg::QCOUNT_BITS:0]        occupancy;

   logic                                  sq_valid_ff, sq_valid_in;
   logic                                  sq_close_ff;
   logic [LENGTH_BITS-1:0]                sq_count_ff;
   logic [2*SAMPLE_BITS-1:0]              sq_ff, sq_in;

   logic [SUM_BITS-1:0]                   sum_ff, sum_in;
   logic [SUM_BITS-1:0]                   total;

   // A closing item in the square stage still needs a queue slot
   assign occupancy = {1'b0, queue_status.count}
                    + (rmsw_pkg::QCOUNT_BITS + 1)'(sq_valid_ff & sq_close_ff);
   assign req_full  = occupancy >= (rmsw_pkg::QCOUNT_BITS + 1)'(rmsw_pkg::QUEUE_DEPTH);
   assign accept    = req_push & ~req_full;

   assign len_eff    = (window_ff == '0) ? LENGTH_BITS'(1) : window_ff;
   assign count_next = count_ff + LENGTH_BITS'(1);
   assign close_now  = (count_next == '0) || (count_next >= len_eff);
   assign sq_in      = (2*SAMPLE_BITS)'(req_sample) * (2*SAMPLE_BITS)'(req_sample);
   assign sq_valid_in = accept;

   always_comb begin
      window_in = window_ff;
      if (csr_write) begin
         window_in = csr_window_length;
      end
      count_in = count_ff;
      if (accept) begin
         count_in = close_now ? '0 : count_next;
      end
   end

   // Accumulate; drop the sum when the window closes
   assign total = sum_ff + SUM_BITS'(sq_ff);

   always_comb begin
      sum_in     = sum_ff;
      queue_push = 1'b0;
      if (sq_valid_ff) begin
         if (sq_close_ff) begin
            queue_push = 1'b1;
            sum_in     = '0;
         end else begin
            sum_in = total;
         end
      end
   end

   assign queue_data = {total, sq_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= LENGTH_BITS'(rmsw_pkg::WINDOW_RESET);
         count_ff    <= '0;
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         window_ff   <= window_in;
         count_ff    <= count_in;
         sq_valid_ff <= sq_valid_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff       <= sq_in;
         sq_close_ff <= close_now;
         sq_count_ff <= count_next;
      end
   end

endmodule

// ===== rtl/rmsw_fifo.sv =====
// Short queue of closed windows between the front end and the back end.
// Depends on rmsw_pkg for depth and status type.
`timescale 1ns / 1ps

module rmsw_fifo #(
   parameter int unsigned DATA_BITS = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_BITS-1:0]        push_data,
   input  logic                        pop,
   output logic [DATA_BITS-1:0]        pop_data,
   output rmsw_pkg::queue_status_type  status
);

   logic [DATA_BITS-1:0]             entries_ff [rmsw_pkg::QUEUE_DEPTH];
   logic [rmsw_pkg::PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rmsw_pkg::PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rmsw_pkg::QCOUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [rmsw_pkg::PTR_BITS-1:0] ptr_step(
      input logic [rmsw_pkg::PTR_BITS-1:0] ptr);
      logic [rmsw_pkg::PTR_BITS-1:0] nxt;
      if (ptr == rmsw_pkg::PTR_BITS'(rmsw_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + rmsw_pkg::PTR_BITS'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rmsw_pkg::QCOUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rmsw_pkg::QCOUNT_BITS'(1);
      end
   end

   assign pop_data     = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rmsw_back.sv =====
// Back end: restoring divide of the window sum by the sample count, then a
// digit-by-digit integer square root, into a one-entry result register.
// Depends on rmsw_pkg; pops windows from rmsw_fifo.
`timescale 1ns / 1ps

module rmsw_back #(
   parameter int unsigned SAMPLE_BITS = 10,
   parameter int unsigned LENGTH_BITS = 8,
   parameter int unsigned SUM_BITS    = 28
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rmsw_pkg::queue_status_type       queue_status,
   input  logic [SUM_BITS+LENGTH_BITS-1:0]  queue_data,
   output logic                             queue_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [SAMPLE_BITS-1:0]           rsp_rms_value
);

   localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;

   logic [SUM_BITS-1:0]        quo_ff, quo_in;
   logic [LENGTH_BITS-1:0]     rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]     div_ff, div_in;
   logic [LENGTH_BITS:0]       rem_sh;
   logic [LENGTH_BITS:0]       rem_diff;
   logic                       div_ge;
   logic [SUM_BITS-1:0]        quo_next;
   logic [LENGTH_BITS-1:0]     q_count;

   logic [2*SAMPLE_BITS-1:0]   sq_val_ff, sq_val_in;
   logic [SAMPLE_BITS:0]       sq_rem_ff, sq_rem_in;
   logic [SAMPLE_BITS-1:0]     root_ff, root_in;
   logic [SAMPLE_BITS+2:0]     sq_sh;
   logic [SAMPLE_BITS+2:0]     sq_trial;
   logic [SAMPLE_BITS+2:0]     sq_diff;
   logic                       sq_ge;

   logic                       out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]     out_data_ff, out_data_in;
   logic                       out_free;

   assign q_count = queue_data[LENGTH_BITS-1:0];

   // One quotient bit per cycle
   assign rem_sh   = {rem_ff, quo_ff[SUM_BITS-1]};
   assign div_ge   = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign quo_next = {quo_ff[SUM_BITS-2:0], div_ge};

   // One root bit per cycle
   assign sq_sh    = {sq_rem_ff, sq_val_ff[2*SAMPLE_BITS-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;
   assign sq_diff  = sq_sh - sq_trial;

   assign out_free  = ~out_valid_ff | rsp_pop;
   assign queue_pop = (state_ff == ST_IDLE) & ~queue_status.empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      sq_val_in    = sq_val_ff;
      sq_rem_in    = sq_rem_ff;
      root_in      = root_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               quo_in   = queue_data[SUM_BITS+LENGTH_BITS-1:LENGTH_BITS];
               rem_in   = '0;
               div_in   = (q_count == '0) ? LENGTH_BITS'(1) : q_count;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in  = quo_next;
            rem_in  = div_ge ? rem_diff[LENGTH_BITS-1:0] : rem_sh[LENGTH_BITS-1:0];
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               // Mean never exceeds the largest square, so the low bits hold it
               sq_val_in = quo_next[2*SAMPLE_BITS-1:0];
               sq_rem_in = '0;
               root_in   = '0;
               step_in   = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_val_in = {sq_val_ff[2*SAMPLE_BITS-3:0], 2'b00};
            sq_rem_in = sq_ge ? sq_diff[SAMPLE_BITS:0] : sq_sh[SAMPLE_BITS:0];
            root_in   = {root_ff[SAMPLE_BITS-2:0], sq_ge};
            step_in   = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_data_in  = root_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_empty     = ~out_valid_ff;
   assign rsp_rms_value = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      sq_val_ff   <= sq_val_in;
      sq_rem_ff   <= sq_rem_in;
      root_ff     <= root_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== rtl/rms_over_sample_window.sv =====
// RMS over a sample window: floor(sqrt(floor(sum of squares / count))).
// Throughput: one sample per cycle while req_full is low; the back end runs each
// window through the one-bit-per-cycle divider and root before it pops the next.
// Reset (synchronous, high): window length 30, empty accumulator and queues.
`timescale 1ns / 1ps

module rms_over_sample_window #(
   parameter int unsigned SAMPLE_BITS = 10,
   parameter int unsigned LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample input, queue style
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   // Result output, queue style
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [SAMPLE_BITS-1:0] rsp_rms_value,
   // Window length register
   input  logic                   csr_write,
   input  logic [LENGTH_BITS-1:0] csr_window_length
);

   // Sum of up to 2^LENGTH_BITS - 1 full-scale squares never wraps
   localparam int unsigned SUM_BITS   = 2 * SAMPLE_BITS + LENGTH_BITS;
   localparam int unsigned ENTRY_BITS = SUM_BITS + LENGTH_BITS;

   rmsw_pkg::queue_status_type queue_status;
   logic                       queue_push;
   logic                       queue_pop;
   logic [ENTRY_BITS-1:0]      queue_wdata;
   logic [ENTRY_BITS-1:0]      queue_rdata;

   // Front end: one sample transfer per cycle while req_full is low. Square
   // in the first stage, accumulate in the second; a closing sample pushes
   // {sum, count} into the queue. Hold off new samples (req_full) only when the
   // queue plus a closing item still in flight would fill it.
   rmsw_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample        (req_sample),
      .csr_write         (csr_write),
      .csr_window_length (csr_window_length),
      .queue_status      (queue_status),
      .queue_push        (queue_push),
      .queue_data        (queue_wdata)
   );

   // Decouple sample intake from the slow divide/root work.
   rmsw_fifo #(
      .DATA_BITS (ENTRY_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_wdata),
      .pop       (queue_pop),
      .pop_data  (queue_rdata),
      .status    (queue_status)
   );

   // Back end: pop a closed window, divide the sum by the count one bit a
   // cycle, take the root one bit a cycle, then park the value in the result
   // register. Advance to the next window while an earlier result still waits
   // only up to the final hand-off into that register.
   rmsw_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .queue_data    (queue_rdata),
      .queue_pop     (queue_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_rms_value (rsp_rms_value)
   );

endmodule
